// ----- rtl/rsh_pkg.sv -----
// Shared types, constants and helpers for the real spherical harmonic evaluator.
// Used by rsh_front, rsh_queue, rsh_back and real_sh_basis_eval.
// No dependencies.
package rsh_pkg;

    // Default width of one direction component at the ports
    localparam int COORD_BITS_DEF = 16;

    // Internal coordinate width: Q1.15 plus one bit so that +1.0 is representable
    localparam int CRD_W = 17;

    // Basis index band*band + band + order, 0 to 24
    localparam int IDX_W = 5;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Work item handed from the front end to the evaluation pipeline
    typedef struct packed {
        logic                    bad;
        logic [IDX_W-1:0]        idx;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } rsh_item_t;

    // Coefficients in Q28: constant with 9 decimals, times 2^28, rounded
    localparam logic signed [63:0] QC_D  = 64'sd1000000000;
    localparam logic signed [63:0] QC_H  = 64'sd500000000;
    localparam logic signed [63:0] QC_S  = 64'sd268435456;
    localparam logic signed [63:0] QC_00 = (64'sd282094792  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_01 = (64'sd488602512  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_04 = (64'sd1092548431 * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_06 = (64'sd315391565  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_08 = (64'sd546274215  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_09 = (64'sd590043590  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_10 = (64'sd2890611443 * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_11 = (64'sd457045799  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_12 = (64'sd373176333  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_14 = (64'sd1445305721 * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_16 = (64'sd2503342942 * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_17 = (64'sd1770130770 * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_18 = (64'sd946174696  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_19 = (64'sd669046544  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_20 = (64'sd105785547  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_22 = (64'sd473087348  * QC_S + QC_H) / QC_D;
    localparam logic signed [63:0] QC_24 = (64'sd625835735  * QC_S + QC_H) / QC_D;

    // Arithmetic right shift, round to nearest, ties away from zero
    function automatic logic signed [63:0] rshr64(input logic signed [63:0] v,
                                                  input int unsigned s);
        logic signed [63:0] h;
        logic signed [63:0] neg;
        h   = 64'sd1 <<< ((s == 0) ? 0 : (s - 1));
        neg = $signed({63'd0, v[63]});
        if (s == 0)
        begin
            return v;
        end
        return (v + h - neg) >>> s;
    endfunction

    // Coefficient table, including the Condon-Shortley sign
    function automatic logic signed [30:0] coef_q28(input logic [IDX_W-1:0] idx);
        logic signed [63:0] c;
        case (idx)
            5'd0:    c = QC_00;
            5'd1:    c = -QC_01;
            5'd2:    c = QC_01;
            5'd3:    c = -QC_01;
            5'd4:    c = QC_04;
            5'd5:    c = -QC_04;
            5'd6:    c = QC_06;
            5'd7:    c = -QC_04;
            5'd8:    c = QC_08;
            5'd9:    c = -QC_09;
            5'd10:   c = QC_10;
            5'd11:   c = -QC_11;
            5'd12:   c = QC_12;
            5'd13:   c = -QC_11;
            5'd14:   c = QC_14;
            5'd15:   c = -QC_09;
            5'd16:   c = QC_16;
            5'd17:   c = -QC_17;
            5'd18:   c = QC_18;
            5'd19:   c = -QC_19;
            5'd20:   c = QC_20;
            5'd21:   c = -QC_19;
            5'd22:   c = QC_22;
            5'd23:   c = -QC_17;
            5'd24:   c = QC_24;
            default: c = 64'sd0;
        endcase
        return c[30:0];
    endfunction

endpackage

// ----- rtl/rsh_front.sv -----
// Front end: accepts directions, checks the band/order index and converts
// coordinates to Q1.15. Depends on rsh_pkg.
module rsh_front #(
    parameter int COORD_BITS = rsh_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2:0]                    band,
    input  logic signed [3:0]             order,
    input  logic signed [COORD_BITS-1:0]  dir_x,
    input  logic signed [COORD_BITS-1:0]  dir_y,
    input  logic signed [COORD_BITS-1:0]  dir_z,
    output logic                          push_valid,
    input  logic                          push_ready,
    output rsh_pkg::rsh_item_t            push_item
);

    localparam int unsigned UP = (COORD_BITS < 16) ? (16 - COORD_BITS) : 0;
    localparam int unsigned DN = (COORD_BITS > 16) ? (COORD_BITS - 16) : 0;

    logic               hold_vld_reg;
    logic               hold_vld_next;
    rsh_pkg::rsh_item_t item_reg;
    rsh_pkg::rsh_item_t item_next;
    logic               take;
    logic signed [5:0]  band_s;
    logic signed [5:0]  order_s;
    logic signed [5:0]  idx_full;

    // Coordinate to Q1.15: round wider inputs to nearest, shift up narrower ones
    function automatic logic signed [rsh_pkg::CRD_W-1:0] to_q15(
        input logic signed [COORD_BITS-1:0] raw);
        logic signed [63:0] v;
        logic signed [63:0] q;
        v = 64'(raw);
        q = (DN > 0) ? rsh_pkg::rshr64(v, DN) : (v <<< UP);
        return q[rsh_pkg::CRD_W-1:0];
    endfunction

    assign s_axis_tready = !hold_vld_reg || push_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Index check and flattening
    assign band_s   = $signed({3'b000, band});
    assign order_s  = 6'(order);
    assign idx_full = 6'(band_s * band_s + band_s + order_s);

    always_comb
    begin
        item_next.bad = (band > 3'd4) || (order_s > band_s) || (order_s < -band_s);
        item_next.idx = idx_full[rsh_pkg::IDX_W-1:0];
        item_next.x   = to_q15(dir_x);
        item_next.y   = to_q15(dir_y);
        item_next.z   = to_q15(dir_z);
    end

    // Holding stage valid
    always_comb
    begin
        if (take)
            hold_vld_next = 1'b1;
        else if (push_ready)
            hold_vld_next = 1'b0;
        else
            hold_vld_next = hold_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_vld_reg <= 1'b0;
        else
            hold_vld_reg <= hold_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign push_valid = hold_vld_reg;
    assign push_item  = item_reg;

endmodule

// ----- rtl/rsh_queue.sv -----
// Short queue of work items between the front end and the evaluation pipeline.
// Depends on rsh_pkg.
module rsh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  rsh_pkg::rsh_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output rsh_pkg::rsh_item_t pop_item
);

    localparam int PTR_W = $clog2(rsh_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rsh_pkg::QUEUE_DEPTH + 1);

    rsh_pkg::rsh_item_t slot_reg [rsh_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    // Full does not look at pop, so no path runs from back to front
    assign push_ready = (count_reg != CNT_W'(rsh_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/rsh_back.sv -----
// Evaluation pipeline: products, polynomial factors, shared multiply,
// coefficient scaling and saturation, six stages. Depends on rsh_pkg.
module rsh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  rsh_pkg::rsh_item_t pop_item,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,
    output logic               m_axis_tuser
);

    typedef enum logic [1:0] {SH_NONE, SH_15, SH_28} shift_kind_t;

    localparam logic signed [33:0] Q_ONE   = 34'sd1 <<< 28;
    localparam logic signed [33:0] Q_THREE = 34'sd3 <<< 28;

    localparam int IW = rsh_pkg::IDX_W;
    localparam int CW = rsh_pkg::CRD_W;

    logic adv;

    // Stage valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;

    // Stage 1: second-order products
    logic signed [CW-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [29:0]   s1_x2_reg, s1_y2_reg, s1_z2_reg;
    logic signed [29:0]   s1_xy_reg, s1_xz_reg, s1_yz_reg;
    logic signed [29:0]   s1_x2_next, s1_y2_next, s1_z2_next;
    logic signed [29:0]   s1_xy_next, s1_xz_next, s1_yz_next;
    logic [IW-1:0]        s1_idx_reg;
    logic                 s1_bad_reg;

    // Stage 2: multiply operands
    logic signed [33:0] s2_a0_reg, s2_a0_next;
    logic signed [29:0] s2_b0_reg, s2_b0_next;
    logic signed [29:0] s2_a1_reg, s2_a1_next;
    logic signed [29:0] s2_b1_reg, s2_b1_next;
    shift_kind_t        s2_sh_reg, s2_sh_next;
    logic               s2_off_reg, s2_off_next;
    logic [IW-1:0]      s2_idx_reg;
    logic               s2_bad_reg;

    // Stage 3: products
    logic signed [63:0] s3_p0_reg, s3_p0_next;
    logic signed [59:0] s3_p1_reg, s3_p1_next;
    shift_kind_t        s3_sh_reg;
    logic               s3_off_reg;
    logic [IW-1:0]      s3_idx_reg;
    logic               s3_bad_reg;

    // Stage 4: polynomial in Q28 and its coefficient
    logic signed [63:0] s4_sum;
    logic signed [63:0] s4_rnd;
    logic signed [33:0] s4_poly_reg, s4_poly_next;
    logic signed [30:0] s4_coef_reg, s4_coef_next;
    logic               s4_bad_reg;

    // Stage 5: scaled value in Q56
    logic signed [63:0] s5_prod_reg, s5_prod_next;
    logic               s5_bad_reg;

    // Stage 6: output register
    logic signed [63:0] s6_rnd;
    logic [15:0]        s6_val_reg, s6_val_next;
    logic               s6_bad_reg;

    function automatic logic signed [29:0] prod_q28(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [33:0] p;
        logic signed [63:0] r;
        p = a * b;
        r = rsh_pkg::rshr64(64'(p), 2);
        return r[29:0];
    endfunction

    // The whole pipeline moves when the output register is free
    assign adv       = !s6_vld_reg || m_axis_tready;
    assign pop_ready = adv;

    // Stage 1 logic
    always_comb
    begin
        s1_x2_next = prod_q28(pop_item.x, pop_item.x);
        s1_y2_next = prod_q28(pop_item.y, pop_item.y);
        s1_z2_next = prod_q28(pop_item.z, pop_item.z);
        s1_xy_next = prod_q28(pop_item.x, pop_item.y);
        s1_xz_next = prod_q28(pop_item.x, pop_item.z);
        s1_yz_next = prod_q28(pop_item.y, pop_item.z);
    end

    // Stage 2: pick the factor pair for each basis function (two pairs for index 24)
    always_comb
    begin
        logic signed [33:0] ex2, ey2, ez2, exy, exz, eyz;
        logic signed [33:0] xm, ym, zm;
        ex2 = 34'(s1_x2_reg);
        ey2 = 34'(s1_y2_reg);
        ez2 = 34'(s1_z2_reg);
        exy = 34'(s1_xy_reg);
        exz = 34'(s1_xz_reg);
        eyz = 34'(s1_yz_reg);
        xm  = 34'(s1_x_reg);
        ym  = 34'(s1_y_reg);
        zm  = 34'(s1_z_reg);
        s2_a0_next  = 34'sd0;
        s2_b0_next  = 30'sd1;
        s2_a1_next  = 30'sd0;
        s2_b1_next  = 30'sd0;
        s2_sh_next  = SH_NONE;
        s2_off_next = 1'b0;
        case (s1_idx_reg)
            5'd0:  s2_a0_next = Q_ONE;
            5'd1:  s2_a0_next = ym <<< 13;
            5'd2:  s2_a0_next = zm <<< 13;
            5'd3:  s2_a0_next = xm <<< 13;
            5'd4:  s2_a0_next = exy;
            5'd5:  s2_a0_next = eyz;
            5'd6:  s2_a0_next = 34'sd3 * ez2 - Q_ONE;
            5'd7:  s2_a0_next = exz;
            5'd8:  s2_a0_next = ex2 - ey2;
            5'd9:
            begin
                s2_a0_next = 34'sd3 * ex2 - ey2;
                s2_b0_next = 30'(s1_y_reg);
                s2_sh_next = SH_15;
            end
            5'd10:
            begin
                s2_a0_next = exy;
                s2_b0_next = 30'(s1_z_reg);
                s2_sh_next = SH_15;
            end
            5'd11:
            begin
                s2_a0_next = 34'sd5 * ez2 - Q_ONE;
                s2_b0_next = 30'(s1_y_reg);
                s2_sh_next = SH_15;
            end
            5'd12:
            begin
                s2_a0_next = 34'sd5 * ez2 - Q_THREE;
                s2_b0_next = 30'(s1_z_reg);
                s2_sh_next = SH_15;
            end
            5'd13:
            begin
                s2_a0_next = 34'sd5 * ez2 - Q_ONE;
                s2_b0_next = 30'(s1_x_reg);
                s2_sh_next = SH_15;
            end
            5'd14:
            begin
                s2_a0_next = ex2 - ey2;
                s2_b0_next = 30'(s1_z_reg);
                s2_sh_next = SH_15;
            end
            5'd15:
            begin
                s2_a0_next = ex2 - 34'sd3 * ey2;
                s2_b0_next = 30'(s1_x_reg);
                s2_sh_next = SH_15;
            end
            5'd16:
            begin
                s2_a0_next = ex2 - ey2;
                s2_b0_next = s1_xy_reg;
                s2_sh_next = SH_28;
            end
            5'd17:
            begin
                s2_a0_next = 34'sd3 * ex2 - ey2;
                s2_b0_next = s1_yz_reg;
                s2_sh_next = SH_28;
            end
            5'd18:
            begin
                s2_a0_next = 34'sd7 * ez2 - Q_ONE;
                s2_b0_next = s1_xy_reg;
                s2_sh_next = SH_28;
            end
            5'd19:
            begin
                s2_a0_next = 34'sd7 * ez2 - Q_THREE;
                s2_b0_next = s1_yz_reg;
                s2_sh_next = SH_28;
            end
            5'd20:
            begin
                // the 35*z2 term wraps in 34 bits, the difference does not
                s2_a0_next  = 34'sd35 * ez2 - 34'sd10 * Q_THREE;
                s2_b0_next  = s1_z2_reg;
                s2_sh_next  = SH_28;
                s2_off_next = 1'b1;
            end
            5'd21:
            begin
                s2_a0_next = 34'sd7 * ez2 - Q_THREE;
                s2_b0_next = s1_xz_reg;
                s2_sh_next = SH_28;
            end
            5'd22:
            begin
                s2_a0_next = 34'sd7 * ez2 - Q_ONE;
                s2_b0_next = 30'(ex2 - ey2);
                s2_sh_next = SH_28;
            end
            5'd23:
            begin
                s2_a0_next = ex2 - 34'sd3 * ey2;
                s2_b0_next = s1_xz_reg;
                s2_sh_next = SH_28;
            end
            5'd24:
            begin
                s2_a0_next = ex2 - 34'sd6 * ey2;
                s2_b0_next = s1_x2_reg;
                s2_a1_next = s1_y2_reg;
                s2_b1_next = s1_y2_reg;
                s2_sh_next = SH_28;
            end
            default: s2_a0_next = 34'sd0;
        endcase
    end

    // Stage 3 multipliers
    assign s3_p0_next = s2_a0_reg * s2_b0_reg;
    assign s3_p1_next = s2_a1_reg * s2_b1_reg;

    // Stage 4: sum, rounding shift, constant offset, coefficient lookup
    assign s4_sum = s3_p0_reg + 64'(s3_p1_reg);

    always_comb
    begin
        case (s3_sh_reg)
            SH_15:   s4_rnd = rsh_pkg::rshr64(s4_sum, 15);
            SH_28:   s4_rnd = rsh_pkg::rshr64(s4_sum, 28);
            default: s4_rnd = s4_sum;
        endcase
        s4_poly_next = s4_rnd[33:0] + (s3_off_reg ? Q_THREE : 34'sd0);
        s4_coef_next = rsh_pkg::coef_q28(s3_idx_reg);
    end

    // Stage 5 multiplier
    assign s5_prod_next = s4_poly_reg * s4_coef_reg;

    // Stage 6: Q56 to Q15, saturate, zero on a bad index
    assign s6_rnd = rsh_pkg::rshr64(s5_prod_reg, 41);

    always_comb
    begin
        if (s5_bad_reg)
            s6_val_next = 16'd0;
        else if (s6_rnd > 64'sd32767)
            s6_val_next = 16'h7FFF;
        else if (s6_rnd < -64'sd32768)
            s6_val_next = 16'h8000;
        else
            s6_val_next = s6_rnd[15:0];
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= pop_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= pop_item.x;
            s1_y_reg    <= pop_item.y;
            s1_z_reg    <= pop_item.z;
            s1_x2_reg   <= s1_x2_next;
            s1_y2_reg   <= s1_y2_next;
            s1_z2_reg   <= s1_z2_next;
            s1_xy_reg   <= s1_xy_next;
            s1_xz_reg   <= s1_xz_next;
            s1_yz_reg   <= s1_yz_next;
            s1_idx_reg  <= pop_item.idx;
            s1_bad_reg  <= pop_item.bad;

            s2_a0_reg   <= s2_a0_next;
            s2_b0_reg   <= s2_b0_next;
            s2_a1_reg   <= s2_a1_next;
            s2_b1_reg   <= s2_b1_next;
            s2_sh_reg   <= s2_sh_next;
            s2_off_reg  <= s2_off_next;
            s2_idx_reg  <= s1_idx_reg;
            s2_bad_reg  <= s1_bad_reg;

            s3_p0_reg   <= s3_p0_next;
            s3_p1_reg   <= s3_p1_next;
            s3_sh_reg   <= s2_sh_reg;
            s3_off_reg  <= s2_off_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_bad_reg  <= s2_bad_reg;

            s4_poly_reg <= s4_poly_next;
            s4_coef_reg <= s4_coef_next;
            s4_bad_reg  <= s3_bad_reg;

            s5_prod_reg <= s5_prod_next;
            s5_bad_reg  <= s4_bad_reg;

            s6_val_reg  <= s6_val_next;
            s6_bad_reg  <= s5_bad_reg;
        end
    end

    assign m_axis_tvalid = s6_vld_reg;
    assign m_axis_tdata  = s6_val_reg;
    assign m_axis_tuser  = s6_bad_reg;

endmodule

// ----- rtl/real_sh_basis_eval.sv -----
// Real spherical harmonic basis, bands 0 to 4, one direction per transaction.
// Throughput: one transaction per cycle while m_axis_tready is high; the back
// pipeline and the queue each move one item per clock when the output is not stalled.
// Path from input acceptance to the result on m_axis: one front register,
// one queue slot, six pipeline stages (three multiplier levels).
// Reset (rst_n low, asynchronous) empties the queue and all valid flags.
module real_sh_basis_eval #(
    parameter int COORD_BITS = rsh_pkg::COORD_BITS_DEF,
    localparam int S_TDATA_W = ((7 + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // band[2:0], order[3:0], dir_x, dir_y, dir_z (COORD_BITS each), zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // basis_value[15:0]
    output logic [15:0]          m_axis_tdata,
    // bad_index
    output logic                 m_axis_tuser
);

    localparam int X_LO = 7;
    localparam int Y_LO = X_LO + COORD_BITS;
    localparam int Z_LO = Y_LO + COORD_BITS;

    logic               push_valid;
    logic               push_ready;
    rsh_pkg::rsh_item_t push_item;
    logic               pop_valid;
    logic               pop_ready;
    rsh_pkg::rsh_item_t pop_item;

    // Front end
    rsh_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .band          (s_axis_tdata[2:0]),
        .order         ($signed(s_axis_tdata[6:3])),
        .dir_x         ($signed(s_axis_tdata[X_LO +: COORD_BITS])),
        .dir_y         ($signed(s_axis_tdata[Y_LO +: COORD_BITS])),
        .dir_z         ($signed(s_axis_tdata[Z_LO +: COORD_BITS])),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // Decoupling queue
    rsh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Evaluation pipeline
    rsh_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A flagged index always yields a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'd0))
        else $error("bad index result is not zero");

    // Input back-pressure only while the front register holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> push_valid)
        else $error("input stalled with empty front register");

    // A stalled output freezes the pipeline, so nothing leaves the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(pop_valid && pop_ready))
        else $error("queue popped while output stalled");

endmodule
